@@ design/lrtpa_pkg.sv @@
// Shared types, constants and register indexes for the LED ring tail and pulse animator.
// No dependencies; imported by every other file of the block.
package lrtpa_pkg;

    localparam int PIXEL_COUNT = 24;
    localparam int PIX_W       = 6;
    localparam int LEN_W       = 7;
    localparam int NUM_W       = 14;
    localparam int DEN_W       = 6;
    localparam int LVL_W       = 8;

    localparam logic [LEN_W-1:0] LEN_MIN   = 7'd2;
    localparam logic [LEN_W-1:0] LEN_MAX   = 7'd64;
    localparam logic [LVL_W-1:0] PULSE_STEP = 8'd5;
    localparam logic [LVL_W-1:0] LVL_FULL   = 8'd255;

    localparam logic [6:0]  RST_TAIL_LENGTH = 7'd9;
    localparam logic [15:0] RST_STEP_PERIOD = 16'd120;
    localparam logic [31:0] RST_TAIL_DUR    = 32'd60000;
    localparam logic [31:0] RST_PULSE_DUR   = 32'd300000;

    typedef enum logic [1:0] {
        REG_TAIL_LENGTH = 2'd0,
        REG_STEP_PERIOD = 2'd1,
        REG_TAIL_DUR    = 2'd2,
        REG_PULSE_DUR   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_GREEN  = 3'd1,
        MODE_YELLOW = 3'd2,
        MODE_RED    = 3'd3,
        MODE_PULSE  = 3'd4
    } t_mode;

    localparam logic OP_SET    = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_STEP,
        S_PIX,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [LVL_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ design/lrtpa_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, 8-bit quotient.
// Depends on lrtpa_pkg. Caller guarantees num < den * 256.
module lrtpa_div import lrtpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                   r_busy;
    logic                   r_done;
    logic [2:0]             r_cnt;
    logic [NUM_W-1:0]       r_rem;
    logic [DEN_W+6:0]       r_sh;
    logic [LVL_W-1:0]       r_quot;
    logic                   fits;

    assign fits = (r_rem >= {1'b0, r_sh});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd7;
            end else if (r_busy) begin
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 3'd1;
                end
            end
        end
    end

    // datapath: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= i_req.num;
            r_sh   <= {i_req.den, 7'b0};
            r_quot <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - {1'b0, r_sh};
            end
            r_quot <= {r_quot[LVL_W-2:0], fits};
            r_sh   <= r_sh >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ design/led_ring_tail_and_pulse_animator_top.sv @@
// Top level of the LED ring tail and pulse animator: sequencer, shared compare, output register.
// Depends on lrtpa_pkg and lrtpa_div.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction: opcode, new_mode, now_ms.
//   A set transaction (opcode 0) stores the mode and start time and clears the animation
//   state; it produces no pixels and the block is ready again the next cycle.
//   An update transaction (opcode 1) draws no pixels on timeout (red then turns to pulse,
//   other modes to idle) or if no tail step is due; else it draws one frame of PIXEL_COUNT
//   pixels on the output channel (o_valid / i_stall), pixel 0 first, o_last_pixel on the last.
//   Work of an update: a check (timeout) through the shared 32-bit subtract/compare, then
//   a step check in tail modes, then per pixel an output for fill frames, a setup and an
//   output for dark tail pixels, and for lit ones also a wait on the 8-step shared divider.
//   o_stall is high while a transaction is in work; one transaction at a time.
//   The output register parts the channels: the next transaction is taken while the last
//   pixel still waits. While i_stall is high and o_valid is set, the sequencer holds its next pixel.
//   Reset (i_rst_n low, synchronous) clears the mode to idle, the animation state, and
//   loads the register defaults. Config writes (i_cfg_we) are registered, no read-back.
module led_ring_tail_and_pulse_animator_top import lrtpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    // input channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_opcode,
    input  logic [2:0]          i_new_mode,
    input  logic [31:0]         i_now_ms,
    // output channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [PIX_W-1:0]    o_pixel_index,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic                o_last_pixel
);

    // config registers
    logic [6:0]  r_tail_length;
    logic [15:0] r_step_period;
    logic [31:0] r_tail_dur;
    logic [31:0] r_pulse_dur;

    // animation state
    t_state           r_state, n_state;
    t_mode            r_mode, n_mode;
    logic [31:0]      r_mode_start, n_mode_start;
    logic [PIX_W-1:0] r_head, n_head;
    logic [31:0]      r_last_step, n_last_step;
    logic [LVL_W-1:0] r_pulse_lvl, n_pulse_lvl;
    logic             r_pulse_up, n_pulse_up;

    // per-transaction work registers
    logic [31:0]      r_now, n_now;
    logic             r_fill, n_fill;
    logic [LVL_W-1:0] r_level, n_level;
    logic [PIX_W-1:0] r_pix, n_pix;

    // output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pix;
    logic [7:0]       r_out_red, r_out_green, r_out_blue;
    logic             r_out_last;

    logic             in_take;
    logic             out_free;
    logic             load_out;
    logic             pix_last;

    t_div_req         div_req;
    t_div_rsp         div_rsp;

    // shared subtract/compare: (a - b) >= c, modulo 2^32
    logic [31:0]      cmp_a, cmp_b, cmp_c;
    logic             cmp_ge;

    // tail geometry for the current pixel
    logic [LEN_W-1:0] tail_len;
    logic [LEN_W-1:0] tail_off;
    logic             lit;
    logic [DEN_W-1:0] fade_x;

    logic             red_on, green_on;

    assign in_take  = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign pix_last = (r_pix == PIX_W'(PIXEL_COUNT - 1));
    assign load_out = (r_state == S_EMIT) && out_free;

    always_comb begin
        cmp_a = r_now;
        cmp_b = r_mode_start;
        cmp_c = (r_mode == MODE_PULSE) ? r_pulse_dur : r_tail_dur;
        if (r_state == S_STEP) begin
            cmp_b = r_last_step;
            cmp_c = {16'b0, r_step_period};
        end
    end
    assign cmp_ge = ((cmp_a - cmp_b) >= cmp_c);

    always_comb begin
        if (r_tail_length < LEN_MIN) begin
            tail_len = LEN_MIN;
        end else if (r_tail_length > LEN_MAX) begin
            tail_len = LEN_MAX;
        end else begin
            tail_len = r_tail_length;
        end
    end

    // distance behind the head, mod PIXEL_COUNT
    assign tail_off = (r_head >= r_pix)
                    ? LEN_W'(r_head - r_pix)
                    : LEN_W'({1'b0, r_head} + LEN_W'(PIXEL_COUNT) - {1'b0, r_pix});
    assign lit      = (tail_off < tail_len);
    assign fade_x   = DEN_W'(tail_len - 7'd1 - tail_off);

    assign div_req.start = (r_state == S_PIX) && lit;
    assign div_req.num   = {fade_x, 8'b0} - NUM_W'(fade_x);   // fade_x * 255
    assign div_req.den   = DEN_W'(tail_len - 7'd1);

    lrtpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_take && (i_opcode == OP_UPDATE)) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (r_mode)
                    MODE_GREEN, MODE_YELLOW, MODE_RED: begin
                        n_state = cmp_ge ? S_IDLE : S_STEP;
                    end
                    MODE_PULSE: begin
                        n_state = cmp_ge ? S_IDLE : S_EMIT;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_STEP: begin
                n_state = cmp_ge ? S_PIX : S_IDLE;
            end
            S_PIX: begin
                n_state = lit ? S_DIV : S_EMIT;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (pix_last) begin
                        n_state = S_IDLE;
                    end else if (!r_fill) begin
                        n_state = S_PIX;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and state updates
    always_comb begin
        n_mode       = r_mode;
        n_mode_start = r_mode_start;
        n_head       = r_head;
        n_last_step  = r_last_step;
        n_pulse_lvl  = r_pulse_lvl;
        n_pulse_up   = r_pulse_up;
        n_now        = r_now;
        n_fill       = r_fill;
        n_level      = r_level;
        n_pix        = r_pix;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_now = i_now_ms;
                    n_pix = '0;
                    if (i_opcode == OP_SET) begin
                        n_mode       = (i_new_mode <= 3'(MODE_PULSE)) ? t_mode'(i_new_mode)
                                                                      : MODE_IDLE;
                        n_mode_start = i_now_ms;
                        n_head       = '0;
                        n_last_step  = '0;
                        n_pulse_lvl  = '0;
                        n_pulse_up   = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                case (r_mode)
                    MODE_GREEN, MODE_YELLOW: begin
                        if (cmp_ge) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                    MODE_RED: begin
                        if (cmp_ge) begin
                            n_mode       = MODE_PULSE;
                            n_mode_start = r_now;
                        end
                    end
                    MODE_PULSE: begin
                        if (cmp_ge) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            n_fill = 1'b1;
                            if (r_pulse_up) begin
                                if ({1'b0, r_pulse_lvl} + {1'b0, PULSE_STEP}
                                        >= {1'b0, LVL_FULL}) begin
                                    n_pulse_lvl = LVL_FULL;
                                    n_pulse_up  = 1'b0;
                                end else begin
                                    n_pulse_lvl = r_pulse_lvl + PULSE_STEP;
                                end
                            end else begin
                                if (r_pulse_lvl <= PULSE_STEP) begin
                                    n_pulse_lvl = '0;
                                    n_pulse_up  = 1'b1;
                                end else begin
                                    n_pulse_lvl = r_pulse_lvl - PULSE_STEP;
                                end
                            end
                            n_level = n_pulse_lvl;
                        end
                    end
                    default: begin
                        // idle frame: all black
                        n_mode  = MODE_IDLE;
                        n_fill  = 1'b1;
                        n_level = '0;
                    end
                endcase
            end
            S_STEP: begin
                n_fill = 1'b0;
                if (cmp_ge) begin
                    n_last_step = r_now;
                    n_head      = (r_head == PIX_W'(PIXEL_COUNT - 1)) ? '0 : r_head + 1'b1;
                end
            end
            S_PIX: begin
                if (!lit) begin
                    n_level = '0;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_level = div_rsp.quot;
                end
            end
            S_EMIT: begin
                if (out_free && !pix_last) begin
                    n_pix = r_pix + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign red_on   = r_fill || (r_mode == MODE_YELLOW) || (r_mode == MODE_RED);
    assign green_on = !r_fill && ((r_mode == MODE_GREEN) || (r_mode == MODE_YELLOW));

    // control and animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_mode        <= MODE_IDLE;
            r_mode_start  <= '0;
            r_head        <= '0;
            r_last_step   <= '0;
            r_pulse_lvl   <= '0;
            r_pulse_up    <= 1'b1;
            r_out_valid   <= 1'b0;
            r_tail_length <= RST_TAIL_LENGTH;
            r_step_period <= RST_STEP_PERIOD;
            r_tail_dur    <= RST_TAIL_DUR;
            r_pulse_dur   <= RST_PULSE_DUR;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_mode_start <= n_mode_start;
            r_head       <= n_head;
            r_last_step  <= n_last_step;
            r_pulse_lvl  <= n_pulse_lvl;
            r_pulse_up   <= n_pulse_up;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_TAIL_LENGTH: r_tail_length <= i_cfg_data[6:0];
                    REG_STEP_PERIOD: r_step_period <= i_cfg_data[15:0];
                    REG_TAIL_DUR:    r_tail_dur    <= i_cfg_data;
                    REG_PULSE_DUR:   r_pulse_dur   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // work and output payload
    always_ff @(posedge i_clk) begin
        r_now   <= n_now;
        r_fill  <= n_fill;
        r_level <= n_level;
        r_pix   <= n_pix;
        if (load_out) begin
            r_out_pix   <= r_pix;
            r_out_red   <= red_on ? r_level : 8'd0;
            r_out_green <= green_on ? r_level : 8'd0;
            r_out_blue  <= 8'd0;
            r_out_last  <= pix_last;
        end
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_pixel_index = r_out_pix;
    assign o_red         = r_out_red;
    assign o_green       = r_out_green;
    assign o_blue        = r_out_blue;
    assign o_last_pixel  = r_out_last;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_last_pixel_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && pix_last) |=> (o_valid && o_last_pixel && (r_state == S_IDLE)))
        else $error("frame end not flagged or sequencer not back to idle");

    a_pixel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_index < PIX_W'(PIXEL_COUNT)))
        else $error("pixel index beyond ring size");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head < PIX_W'(PIXEL_COUNT))
        else $error("head position beyond ring size");

    a_fill_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_fill) |=> ((o_green == 8'd0) && (o_blue == 8'd0)))
        else $error("fill frame carries green or blue");
`endif

endmodule
